### rtl/core/slp_pkg.sv
package slp_pkg;

    localparam int COORD_BITS = 12;
    localparam int FIELD_W    = 12;
    localparam int COORD_W    = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
    localparam int PITCH_W    = 14;
    localparam int ADDR_W     = 32;
    localparam int PROD_W     = COORD_W + PITCH_W;
    localparam int TERM_W     = COORD_W + 2;
    localparam int ERR_W      = COORD_W + 4;
    localparam int LEFT_W     = COORD_W + 1;
    localparam int COLOR_W    = 8;
    localparam int STYLE_W    = 16;
    localparam logic [STYLE_W-1:0] STYLE_LSB = 16'h0001;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 48;

    localparam int OFS_X_START = 0;
    localparam int OFS_Y_START = OFS_X_START + FIELD_W;
    localparam int OFS_X_END   = OFS_Y_START + FIELD_W;
    localparam int OFS_Y_END   = OFS_X_END + FIELD_W;
    localparam int OFS_MODE    = OFS_Y_END + FIELD_W;
    localparam int OFS_COLOR   = OFS_MODE + 2;
    localparam int OFS_STYLE   = OFS_COLOR + COLOR_W;
    localparam int OFS_RELOAD  = OFS_STYLE + STYLE_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_BASE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_PITCH = 2'd1;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef enum logic [1:0] {
        MODE_REPLACE,
        MODE_TRANSPARENT,
        MODE_XOR,
        MODE_ERASE
    } mode_t;

    typedef enum logic [1:0] {
        ACT_LEAVE,
        ACT_WRITE,
        ACT_INVERT,
        ACT_UNUSED
    } action_t;

    typedef struct packed {
        logic                is_start;
        logic [COORD_W-1:0]  x1;
        logic [PROD_W-1:0]   prod;
        logic [COORD_W-1:0]  d_major;
        logic [COORD_W-1:0]  d_minor;
        logic                x_major;
        logic                rows_descend;
        mode_t               mode;
        logic [COLOR_W-1:0]  color;
        logic [STYLE_W-1:0]  style;
        logic                reload;
    } item_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              push;
        logic              pop;
    } qstat_t;

    typedef struct packed {
        logic busy;
        logic out_load;
    } bstat_t;

endpackage

### rtl/core/slp_front.sv
module slp_front
    import slp_pkg::*;
(
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [0:0]           s_tuser,
    input  logic [PITCH_W-1:0]   line_pitch,
    output item_t                item
);

    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
    logic [COORD_W-1:0] x2;
    logic [COORD_W-1:0] y2;
    logic               swap;
    logic [COORD_W-1:0] xa;
    logic [COORD_W-1:0] ya;
    logic [COORD_W-1:0] xb;
    logic [COORD_W-1:0] yb;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic               descend;
    logic               x_major;

    assign x1 = s_tdata[OFS_X_START +: COORD_W];
    assign y1 = s_tdata[OFS_Y_START +: COORD_W];
    assign x2 = s_tdata[OFS_X_END +: COORD_W];
    assign y2 = s_tdata[OFS_Y_END +: COORD_W];

    // order endpoints left to right
    assign swap    = x2 < x1;
    assign xa      = swap ? x2 : x1;
    assign ya      = swap ? y2 : y1;
    assign xb      = swap ? x1 : x2;
    assign yb      = swap ? y1 : y2;
    assign dx      = xb - xa;
    assign descend = yb < ya;
    assign dy      = descend ? (ya - yb) : (yb - ya);
    assign x_major = dx >= dy;

    always_comb begin
        item.is_start     = (s_tuser[0] == CMD_START);
        item.x1           = xa;
        item.prod         = PROD_W'(ya) * PROD_W'(line_pitch);
        item.d_major      = x_major ? dx : dy;
        item.d_minor      = x_major ? dy : dx;
        item.x_major      = x_major;
        item.rows_descend = descend;
        item.mode         = mode_t'(s_tdata[OFS_MODE +: 2]);
        item.color        = s_tdata[OFS_COLOR +: COLOR_W];
        item.style        = s_tdata[OFS_STYLE +: STYLE_W];
        item.reload       = s_tdata[OFS_RELOAD];
    end

endmodule

### rtl/core/slp_queue.sv
module slp_queue
    import slp_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  item_t  in_item,
    output logic   out_valid,
    input  logic   out_pop,
    output item_t  out_item,
    output qstat_t status
);

    item_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;

    assign in_ready  = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;
    assign out_item  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    assign status.count = count_reg;
    assign status.push  = push;
    assign status.pop   = pop;

endmodule

### rtl/core/slp_back.sv
module slp_back
    import slp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_valid,
    input  item_t                item,
    output logic                 item_pop,
    input  logic [ADDR_W-1:0]    frame_base,
    input  logic [PITCH_W-1:0]   line_pitch,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [ADDR_W-1:0]    m_addr,
    output action_t              m_action,
    output logic [COLOR_W-1:0]   m_value,
    output logic                 m_last,
    output bstat_t               status
);

    logic                busy_reg;
    logic [LEFT_W-1:0]   left_reg;
    logic [ADDR_W-1:0]   cursor_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic [TERM_W-1:0]   err_add_reg;
    logic [TERM_W-1:0]   err_sub_reg;
    logic                x_major_reg;
    logic                descend_reg;
    mode_t               mode_reg;
    logic [COLOR_W-1:0]  color_reg;
    logic [STYLE_W-1:0]  style_reg;

    logic                m_valid_reg;
    logic [ADDR_W-1:0]   m_addr_reg;
    action_t             m_action_reg;
    logic [COLOR_W-1:0]  m_value_reg;
    logic                m_last_reg;

    logic                out_load;
    logic [STYLE_W-1:0]  style_next;
    logic                style_bit;
    action_t             action;
    logic [COLOR_W-1:0]  value;
    logic signed [ERR_W-1:0] err_sum;
    logic                carry;
    logic signed [ERR_W-1:0] err_next;
    logic [ADDR_W-1:0]   row_step;
    logic [ADDR_W-1:0]   advance;
    logic [ADDR_W-1:0]   cursor_next;
    logic [LEFT_W-1:0]   left_next;
    logic                fin;

    assign item_pop = item_valid && (!m_valid_reg || m_ready);
    assign out_load = item_pop && !item.is_start && busy_reg;

    // rotate left, use the bit that wraps around
    assign style_next = {style_reg[STYLE_W-2:0], style_reg[STYLE_W-1]};
    assign style_bit  = |(style_next & STYLE_LSB);

    always_comb begin
        action = ACT_LEAVE;
        value  = '0;
        case (mode_reg)
            MODE_REPLACE: begin
                action = ACT_WRITE;
                value  = style_bit ? color_reg : '0;
            end
            MODE_TRANSPARENT: begin
                if (style_bit) begin
                    action = ACT_WRITE;
                    value  = color_reg;
                end
            end
            MODE_XOR: begin
                if (style_bit) begin
                    action = ACT_INVERT;
                end
            end
            default: begin
                if (!style_bit) begin
                    action = ACT_WRITE;
                    value  = color_reg;
                end
            end
        endcase
    end

    assign err_sum  = err_reg + ERR_W'(err_add_reg);
    assign carry    = !err_sum[ERR_W-1];
    assign err_next = carry ? (err_sum - ERR_W'(err_sub_reg)) : err_sum;
    assign row_step = descend_reg ? (ADDR_W'(0) - ADDR_W'(line_pitch))
                                  : ADDR_W'(line_pitch);

    always_comb begin
        if (carry) begin
            advance = row_step + ADDR_W'(1);
        end else if (x_major_reg) begin
            advance = ADDR_W'(1);
        end else begin
            advance = row_step;
        end
    end

    assign cursor_next = cursor_reg + advance;
    assign left_next   = (left_reg != '0) ? (left_reg - 1'b1) : left_reg;
    assign fin         = left_next == '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            left_reg    <= '0;
            cursor_reg  <= '0;
            err_reg     <= '0;
            err_add_reg <= '0;
            err_sub_reg <= '0;
            x_major_reg <= 1'b0;
            descend_reg <= 1'b0;
            mode_reg    <= MODE_REPLACE;
            color_reg   <= '0;
            style_reg   <= '1;
            m_valid_reg <= 1'b0;
        end else begin
            if (item_pop && item.is_start) begin
                busy_reg    <= 1'b1;
                left_reg    <= LEFT_W'(item.d_major) + 1'b1;
                cursor_reg  <= frame_base + ADDR_W'(item.prod) + ADDR_W'(item.x1);
                err_reg     <= -ERR_W'(item.d_major);
                err_add_reg <= TERM_W'({item.d_minor, 1'b0});
                err_sub_reg <= TERM_W'({item.d_major, 1'b0});
                x_major_reg <= item.x_major;
                descend_reg <= item.rows_descend;
                mode_reg    <= item.mode;
                color_reg   <= item.color;
                if (item.reload) begin
                    style_reg <= item.style;
                end
            end else if (out_load) begin
                style_reg  <= style_next;
                cursor_reg <= cursor_next;
                err_reg    <= err_next;
                left_reg   <= left_next;
                if (fin) begin
                    busy_reg <= 1'b0;
                end
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_addr_reg   <= cursor_reg;
            m_action_reg <= action;
            m_value_reg  <= value;
            m_last_reg   <= fin;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_addr   = m_addr_reg;
    assign m_action = m_action_reg;
    assign m_value  = m_value_reg;
    assign m_last   = m_last_reg;

    assign status.busy     = busy_reg;
    assign status.out_load = out_load;

endmodule

### rtl/core/styled_line_stepper_unit.sv
// channel  direction  handshake                  payload
// s_       in         s_tvalid / s_tready        tdata line setup, tuser command
// m_       out        m_tvalid / m_tready        tdata pixel, tlast final pixel
// cfg_     in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One item per cycle sustained unless m_ stalls; a step on an active line
// gives its pixel in the cycle after it leaves the queue; a start gives nothing.
// The front multiplies y by the pitch on the way into a four-entry queue;
// the back adds base and x and runs the error loop from that queue.
// Reset is synchronous; no clearing pass.
// A stalled m_ lets the queue fill, and s_tready drops when it is full.
module styled_line_stepper_unit
    import slp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // x_start, y_start, x_end, y_end, draw_mode, pen_color, style_pattern,
    // style_reload, zero fill
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // cmd
    input  logic [0:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // pixel_address, pixel_action, pixel_value, zero fill
    output logic [M_TDATA_W-1:0]   m_tdata,
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [ADDR_W-1:0]  frame_base_reg;
    logic [PITCH_W-1:0] line_pitch_reg;

    item_t              front_item;
    item_t              head_item;
    logic               head_valid;
    logic               head_pop;
    qstat_t             q_stat;
    bstat_t             b_stat;

    logic [ADDR_W-1:0]  out_addr;
    action_t            out_action;
    logic [COLOR_W-1:0] out_value;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_base_reg <= '0;
            line_pitch_reg <= PITCH_W'(640);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_FRAME_BASE: frame_base_reg <= cfg_data[ADDR_W-1:0];
                CFG_LINE_PITCH: line_pitch_reg <= cfg_data[PITCH_W-1:0];
                default: ;
            endcase
        end
    end

    slp_front u_front (
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .line_pitch (line_pitch_reg),
        .item       (front_item)
    );

    slp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (front_item),
        .out_valid (head_valid),
        .out_pop   (head_pop),
        .out_item  (head_item),
        .status    (q_stat)
    );

    slp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (head_valid),
        .item       (head_item),
        .item_pop   (head_pop),
        .frame_base (frame_base_reg),
        .line_pitch (line_pitch_reg),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_addr     (out_addr),
        .m_action   (out_action),
        .m_value    (out_value),
        .m_last     (m_tlast),
        .status     (b_stat)
    );

    assign m_tdata = {{(M_TDATA_W - ADDR_W - 2 - COLOR_W){1'b0}},
                      out_value, out_action, out_addr};

    a_queue_empty_after_reset: assert property (@(posedge aclk)
        !aresetn |=> q_stat.count == '0)
        else $error("queue not empty after reset");

    a_queue_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_stat.push && !q_stat.pop) |=> q_stat.count == $past(q_stat.count) + 1'b1)
        else $error("queue count missed a push");

    a_queue_count_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_stat.pop && !q_stat.push) |=> q_stat.count == $past(q_stat.count) - 1'b1)
        else $error("queue count missed a pop");

    a_pixel_needs_line: assert property (@(posedge aclk) disable iff (!aresetn)
        b_stat.out_load |-> b_stat.busy)
        else $error("pixel emitted with no active line");

endmodule

### tb/styled_line_stepper_unit_test.sv
`timescale 1ns / 1ps

module styled_line_stepper_unit_test;
    import slp_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 90;
    localparam int PHASE_COUNT   = 7;

    typedef struct packed {
        logic               cmd;
        logic [11:0]        xs;
        logic [11:0]        ys;
        logic [11:0]        xe;
        logic [11:0]        ye;
        mode_t              mode;
        logic [COLOR_W-1:0] color;
        logic [STYLE_W-1:0] style;
        logic               reload;
    } line_cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        action_t            act;
        logic [COLOR_W-1:0] value;
        logic               last;
    } pixel_t;

    typedef struct packed {
        line_cmd_t item;
        logic      typed;
        pixel_t    want;
    } directed_row_t;

    localparam line_cmd_t STEP0 = '{CMD_STEP, 12'd0, 12'd0, 12'd0, 12'd0,
                                    MODE_REPLACE, 8'd0, 16'd0, 1'b0};
    localparam pixel_t NO_PIX = '{32'd0, ACT_LEAVE, 8'd0, 1'b0};

    localparam directed_row_t DIRECTED_ROWS [21] = '{
        '{STEP0, 1'b0, NO_PIX},
        '{'{CMD_START, 12'd0, 12'd0, 12'd0, 12'd0, MODE_REPLACE, 8'hFF, 16'h0000, 1'b0},
          1'b0, NO_PIX},
        '{STEP0, 1'b1, '{32'd0, ACT_WRITE, 8'hFF, 1'b1}},
        '{'{CMD_START, 12'd4095, 12'd4095, 12'd4095, 12'd4095, MODE_XOR, 8'h00,
            16'h0000, 1'b1}, 1'b0, NO_PIX},
        '{STEP0, 1'b1, '{32'd2624895, ACT_LEAVE, 8'h00, 1'b1}},
        '{STEP0, 1'b0, NO_PIX},
        '{'{CMD_START, 12'd4095, 12'd0, 12'd4092, 12'd2, MODE_TRANSPARENT, 8'hA5,
            16'hAAAA, 1'b1}, 1'b0, NO_PIX},
        '{STEP0, 1'b0, NO_PIX},
        '{STEP0, 1'b0, NO_PIX},
        '{STEP0, 1'b0, NO_PIX},
        '{STEP0, 1'b0, NO_PIX},
        '{'{CMD_START, 12'd0, 12'd4095, 12'd1, 12'd4090, MODE_ERASE, 8'h5A,
            16'h8001, 1'b1}, 1'b0, NO_PIX},
        '{STEP0, 1'b0, NO_PIX},
        '{STEP0, 1'b0, NO_PIX},
        '{STEP0, 1'b0, NO_PIX},
        '{'{CMD_START, 12'd10, 12'd10, 12'd13, 12'd13, MODE_REPLACE, 8'h3C,
            16'hFFFF, 1'b0}, 1'b0, NO_PIX},
        '{STEP0, 1'b0, NO_PIX},
        '{STEP0, 1'b0, NO_PIX},
        '{STEP0, 1'b0, NO_PIX},
        '{STEP0, 1'b0, NO_PIX},
        '{STEP0, 1'b0, NO_PIX}
    };

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [0:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    logic idle_on     = 1'b1;
    int   mismatches  = 0;
    int   sink_gap    = 0;

    pixel_t pending_pixels [$];

    logic [ADDR_W-1:0]   cfg_base;
    logic [PITCH_W-1:0]  cfg_pitch;
    logic                ln_busy;
    logic [12:0]         ln_left;
    logic [ADDR_W-1:0]   ln_cursor;
    logic signed [15:0]  ln_err;
    logic [13:0]         ln_err_add;
    logic [13:0]         ln_err_sub;
    logic                ln_x_major;
    logic                ln_descend;
    mode_t               ln_mode;
    logic [COLOR_W-1:0]  ln_color;
    logic [STYLE_W-1:0]  ln_style;

    styled_line_stepper_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit trace_pixel(input line_cmd_t c, output pixel_t px);
        logic [11:0]        x1, y1, x2, y2, t;
        logic signed [12:0] dx, dy;
        logic               style_on;
        logic [ADDR_W-1:0]  row_move;
        px = NO_PIX;
        if (c.cmd == CMD_START) begin
            x1 = c.xs;
            y1 = c.ys;
            x2 = c.xe;
            y2 = c.ye;
            if (x2 < x1) begin
                t = x1; x1 = x2; x2 = t;
                t = y1; y1 = y2; y2 = t;
            end
            dx = $signed({1'b0, x2}) - $signed({1'b0, x1});
            dy = $signed({1'b0, y2}) - $signed({1'b0, y1});
            ln_descend = dy < 0;
            if (dy < 0) dy = -dy;
            ln_cursor = cfg_base + 32'(y1) * 32'(cfg_pitch) + 32'(x1);
            ln_mode = c.mode;
            ln_color = c.color;
            if (c.reload) ln_style = c.style;
            ln_x_major = dx >= dy;
            if (ln_x_major) begin
                ln_err_add = {dy, 1'b0};
                ln_err_sub = {dx, 1'b0};
                ln_err = 16'(-dx);
                ln_left = dx[12:0] + 13'd1;
            end else begin
                ln_err_add = {dx, 1'b0};
                ln_err_sub = {dy, 1'b0};
                ln_err = 16'(-dy);
                ln_left = dy[12:0] + 13'd1;
            end
            ln_busy = 1'b1;
            return 1'b0;
        end
        if (!ln_busy) return 1'b0;

        ln_style = {ln_style[STYLE_W-2:0], ln_style[STYLE_W-1]};
        style_on = (ln_style & STYLE_LSB) != '0;
        case (ln_mode)
            MODE_REPLACE: begin
                px.act = ACT_WRITE;
                px.value = style_on ? ln_color : 8'd0;
            end
            MODE_TRANSPARENT: begin
                if (style_on) begin
                    px.act = ACT_WRITE;
                    px.value = ln_color;
                end
            end
            MODE_XOR: begin
                if (style_on) px.act = ACT_INVERT;
            end
            default: begin
                if (!style_on) begin
                    px.act = ACT_WRITE;
                    px.value = ln_color;
                end
            end
        endcase

        px.addr = ln_cursor;
        row_move = ln_descend ? -32'(cfg_pitch) : 32'(cfg_pitch);
        if (ln_x_major) begin
            ln_cursor = ln_cursor + 32'd1;
            ln_err = ln_err + 16'(ln_err_add);
            if (ln_err >= 0) begin
                ln_err = ln_err - 16'(ln_err_sub);
                ln_cursor = ln_cursor + row_move;
            end
        end else begin
            ln_cursor = ln_cursor + row_move;
            ln_err = ln_err + 16'(ln_err_add);
            if (ln_err >= 0) begin
                ln_err = ln_err - 16'(ln_err_sub);
                ln_cursor = ln_cursor + 32'd1;
            end
        end
        if (ln_left != 0) ln_left = ln_left - 13'd1;
        px.last = ln_left == 0;
        if (px.last) ln_busy = 1'b0;
        return 1'b1;
    endfunction

    function automatic line_cmd_t random_line_cmd();
        line_cmd_t c;
        c.cmd    = 1'($urandom_range(0, 1));
        c.xs     = 12'($urandom_range(0, 4095));
        c.ys     = 12'($urandom_range(0, 4095));
        c.xe     = 12'($urandom_range(0, 4095));
        c.ye     = 12'($urandom_range(0, 4095));
        c.mode   = mode_t'(2'($urandom_range(0, 3)));
        c.color  = 8'($urandom_range(0, 255));
        c.style  = 16'($urandom_range(0, 65535));
        c.reload = 1'($urandom_range(0, 1));
        return c;
    endfunction

    task automatic send_line_cmd(input line_cmd_t c, input logic typed, input pixel_t want);
        pixel_t px;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.cmd;
        s_tdata  <= {5'b0, c.reload, c.style, c.color, c.mode, c.ye, c.xe, c.ys, c.xs};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (trace_pixel(c, px)) pending_pixels.push_back(typed ? want : px);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_FRAME_BASE) cfg_base = data;
        else if (idx == CFG_LINE_PITCH) cfg_pitch = data[PITCH_W-1:0];
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_random_lines(input int quota);
        line_cmd_t c;
        int        sent, d, e, len, n, pick;
        sent = 0;
        while (sent < quota) begin
            pick = $urandom_range(0, 19);
            c = random_line_cmd();
            if (pick == 0) begin
                c.cmd = CMD_STEP;
                send_line_cmd(c, 1'b0, NO_PIX);
                sent++;
            end else begin
                c.cmd = CMD_START;
                if (pick == 1) begin
                    n = $urandom_range(1, 24);
                end else begin
                    d = $urandom_range(0, 12);
                    e = $urandom_range(0, 12);
                    c.xs = 12'($urandom_range(0, 4095 - d));
                    c.xe = c.xs + 12'(d);
                    c.ys = 12'($urandom_range(0, 4095 - e));
                    c.ye = c.ys + 12'(e);
                    if ($urandom_range(0, 1)) {c.ys, c.ye} = {c.ye, c.ys};
                    if ($urandom_range(0, 1))
                        {c.xs, c.ys, c.xe, c.ye} = {c.xe, c.ye, c.xs, c.ys};
                    len = ((d > e) ? d : e) + 1;
                    case ($urandom_range(0, 9))
                        0:       n = $urandom_range(0, len - 1);
                        1:       n = len + $urandom_range(1, 2);
                        default: n = len;
                    endcase
                end
                send_line_cmd(c, 1'b0, NO_PIX);
                repeat (n) begin
                    c = random_line_cmd();
                    c.cmd = CMD_STEP;
                    send_line_cmd(c, 1'b0, NO_PIX);
                end
                sent += 1 + n;
            end
        end
    endtask

    always @(posedge aclk) begin : pixel_sink
        pixel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected pixel at pixel_address %h", m_tdata[31:0]);
                mismatches++;
            end else begin
                want = pending_pixels.pop_front();
                if (m_tdata[31:0] !== want.addr) begin
                    $error("pixel_address expected %h got %h", want.addr, m_tdata[31:0]);
                    mismatches++;
                end
                if (action_t'(m_tdata[33:32]) !== want.act) begin
                    $error("pixel_action expected %0d got %0d", want.act, m_tdata[33:32]);
                    mismatches++;
                end
                if (m_tdata[41:34] !== want.value) begin
                    $error("pixel_value expected %h got %h", want.value, m_tdata[41:34]);
                    mismatches++;
                end
                if (m_tlast !== want.last) begin
                    $error("last expected %0d got %0d", want.last, m_tlast);
                    mismatches++;
                end
            end
        end
        if (sink_gap > 0) begin
            m_tready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            m_tready <= 1'b0;
            sink_gap <= $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        logic [ADDR_W-1:0]  base;
        logic [PITCH_W-1:0] pitch;
        cfg_base   = 32'd0;
        cfg_pitch  = 14'd640;
        ln_busy    = 1'b0;
        ln_left    = '0;
        ln_cursor  = '0;
        ln_err     = '0;
        ln_err_add = '0;
        ln_err_sub = '0;
        ln_x_major = 1'b0;
        ln_descend = 1'b0;
        ln_mode    = MODE_REPLACE;
        ln_color   = '0;
        ln_style   = 16'hFFFF;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED_ROWS[i])
            send_line_cmd(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        wait_drained();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0:       begin base = 32'hFFFF_F000; pitch = 14'd8192; end
                1:       begin base = 32'h0000_0000; pitch = 14'd1;    end
                3:       begin base = 32'hFFFF_FFFF; pitch = 14'd0;    end
                4:       begin base = $urandom;      pitch = 14'd640;  end
                5:       begin base = $urandom;      pitch = 14'd8191; end
                default: begin base = $urandom;      pitch = 14'($urandom_range(1, 8192)); end
            endcase
            if (p == PHASE_COUNT - 1) idle_on <= 1'b0;
            write_register(CFG_FRAME_BASE, base);
            write_register(CFG_LINE_PITCH, 32'(pitch));
            send_random_lines(PHASE_ITEMS);
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
